/* rtl/lfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_pkg: shared types and constants of the LRU frame replacer
// Operation codes, request and result payloads, controller command bundle.
// ----------------------------------------------------------------------------
package lfr_pkg;

    // Fixed field widths of the request and result payloads
    localparam int ID_W    = 6;
    localparam int COUNT_W = 7;

    // Operation codes; code 3 is unused and does nothing
    localparam logic [1:0] KIND_VICTIM = 2'd0;
    localparam logic [1:0] KIND_PIN    = 2'd1;
    localparam logic [1:0] KIND_UNPIN  = 2'd2;

    // Request payload
    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] frame_num;
    } lfr_req_t;

    // Result payload
    typedef struct packed {
        logic               victim_valid;
        logic [ID_W-1:0]    victim_frame;
        logic [COUNT_W-1:0] evictable_count;
    } lfr_rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic apply;
    } lfr_cmd_t;

endpackage

/* rtl/lfr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_ctrl: operation sequencer
// Two-state machine: take a request, then apply it in the next cycle and
// raise the result strobe for the cycle after that.
// ----------------------------------------------------------------------------
module lfr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output lfr_pkg::lfr_cmd_t cmd
);
    import lfr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // Sequence: idle until a transfer, then the apply state and back to idle
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.apply   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done_next = cmd.apply;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

/* rtl/lfr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_datapath: recency list, membership flags and list length
// The list is held oldest first in slot 0, so a victim always leaves slot 0
// and an unpinned frame lands at slot list_length. Capture compares the
// frame against every slot; apply closes a gap with a parallel shift.
// ----------------------------------------------------------------------------
module lfr_datapath #(
    parameter int NUM_FRAMES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lfr_pkg::lfr_cmd_t cmd,
    input  lfr_pkg::lfr_req_t item,
    output lfr_pkg::lfr_rsp_t result
);
    import lfr_pkg::*;

    // Only 2**ID_W distinct frames can ever be in the list
    localparam int MAX_IDS = 1 << ID_W;
    localparam int DEPTH   = (NUM_FRAMES < MAX_IDS) ? NUM_FRAMES : MAX_IDS;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LVLS    = $clog2(DEPTH);

    logic [ID_W-1:0]  slot_reg [DEPTH];
    logic [ID_W-1:0]  slot_next [DEPTH];
    logic [DEPTH-1:0] flag_reg;
    logic [DEPTH-1:0] flag_next;
    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] len_next;

    logic [1:0]       kind_reg;
    logic [DEPTH-1:0] sel_reg;
    logic             hit_reg;
    logic [DEPTH-1:0] match_reg;
    lfr_rsp_t         result_reg;
    lfr_rsp_t         result_next;

    logic [DEPTH-1:0] id_sel;
    logic [DEPTH-1:0] slot_match;
    logic [DEPTH-1:0] oldest_sel;
    logic [DEPTH-1:0] pref [LVLS+1];

    // Encode the captured one-hot frame select back to a frame number
    function automatic logic [ID_W-1:0] item_id_hold(input logic [DEPTH-1:0] sel);
        logic [ID_W-1:0] id;
        id = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel[i])
            begin
                id = id | ID_W'(i);
            end
        end
        return id;
    endfunction

    // Decode the request frame, the oldest frame and the per-slot compare
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            id_sel[i]     = (item.frame_num == ID_W'(i));
            oldest_sel[i] = (slot_reg[0] == ID_W'(i));
            slot_match[i] = (slot_reg[i] == item.frame_num) && (CNT_W'(i) < len_reg);
        end
    end

    // Mark every slot at or above the pinned frame: log-depth prefix OR
    always_comb
    begin
        pref[0] = match_reg;
        for (int l = 0; l < LVLS; l++)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i >= (1 << l))
                begin
                    pref[l+1][i] = pref[l][i] | pref[l][i - (1 << l)];
                end
                else
                begin
                    pref[l+1][i] = pref[l][i];
                end
            end
        end
    end

    // Apply the captured operation
    always_comb
    begin
        slot_next   = slot_reg;
        flag_next   = flag_reg;
        len_next    = len_reg;
        result_next = result_reg;
        if (cmd.apply)
        begin
            result_next.victim_valid = 1'b0;
            result_next.victim_frame = '0;
            case (kind_reg)
                KIND_VICTIM:
                begin
                    if (len_reg != '0)
                    begin
                        result_next.victim_valid = 1'b1;
                        result_next.victim_frame = slot_reg[0];
                        for (int i = 0; i < DEPTH - 1; i++)
                        begin
                            slot_next[i] = slot_reg[i+1];
                        end
                        flag_next = flag_reg & ~oldest_sel;
                        len_next  = len_reg - CNT_W'(1);
                    end
                end
                KIND_PIN:
                begin
                    if (hit_reg)
                    begin
                        for (int i = 0; i < DEPTH - 1; i++)
                        begin
                            if (pref[LVLS][i])
                            begin
                                slot_next[i] = slot_reg[i+1];
                            end
                        end
                        flag_next = flag_reg & ~sel_reg;
                        len_next  = len_reg - CNT_W'(1);
                    end
                end
                KIND_UNPIN:
                begin
                    if ((sel_reg != '0) && !hit_reg && (len_reg != CNT_W'(DEPTH)))
                    begin
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (CNT_W'(i) == len_reg)
                            begin
                                slot_next[i] = item_id_hold(sel_reg);
                            end
                        end
                        flag_next = flag_reg | sel_reg;
                        len_next  = len_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
            result_next.evictable_count = COUNT_W'(len_next);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= '0;
            len_reg  <= '0;
        end
        else
        begin
            flag_reg <= flag_next;
            len_reg  <= len_next;
        end
    end

    // Hold list slots, captured request and result
    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        result_reg <= result_next;
        if (cmd.capture)
        begin
            kind_reg  <= item.kind;
            sel_reg   <= id_sel;
            hit_reg   <= |(flag_reg & id_sel);
            match_reg <= slot_match;
        end
    end

    assign result = result_reg;

endmodule

/* rtl/lru_frame_replacer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_frame_replacer_top: LRU replacer for buffer pool frames
// Every request (victim, pin, unpin) is captured, then applied: busy is high
// for the cycle after the transfer, in which the list is updated, and right
// after that done is high for exactly one cycle with the result on result,
// which holds it until the next update, while the block is already able to
// take the next request. The compare stage over all list slots is followed
// by the shift and update stage. The receiver cannot hold results off;
// sample result whenever done is high.
// ----------------------------------------------------------------------------
module lru_frame_replacer_top #(
    parameter int NUM_FRAMES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lfr_pkg::lfr_req_t item,
    output logic              done,
    output lfr_pkg::lfr_rsp_t result
);
    import lfr_pkg::*;

    localparam int MAX_IDS = 1 << ID_W;
    localparam int DEPTH   = (NUM_FRAMES < MAX_IDS) ? NUM_FRAMES : MAX_IDS;

    lfr_cmd_t cmd;

    lfr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    lfr_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

    // A transfer is followed by exactly one busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy ##1 !busy))
        else $error("busy did not last exactly one cycle after a transfer");

    // Each result strobe follows a busy cycle and lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> ($past(busy) ##1 !done))
        else $error("result strobe out of sequence");

    // A result without an eviction carries frame zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.victim_valid) |-> (result.victim_frame == '0))
        else $error("nonzero frame without eviction");

    // The list never holds more frames than there are distinct frames
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(result.evictable_count) <= 32'(DEPTH)))
        else $error("evictable count out of range");

endmodule

/* test/lru_frame_replacer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_frame_replacer_checker: result predictor and scoreboard for the replacer
// Watches the request and result channels of the replacer. Every request
// transfer updates a private copy of the recency list and queues the result
// it should produce. Every done strobe is compared field by field against
// the oldest queued result. Failures and the number of results still due
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module lru_frame_replacer_checker #(
    parameter int NUM_FRAMES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  lfr_pkg::lfr_req_t item,
    input  logic              done,
    input  lfr_pkg::lfr_rsp_t result,
    output int                errors,
    output int                outstanding
);

    // Private copy of the list: slot 0 holds the most recently unpinned frame
    logic [lfr_pkg::ID_W-1:0] lru_list [NUM_FRAMES];
    logic                     in_list  [NUM_FRAMES];
    int                       list_len;

    // Results owed by the block, oldest first
    lfr_pkg::lfr_rsp_t        due_results [$];

    // Apply one request to the private list and return the result it produces
    function automatic lfr_pkg::lfr_rsp_t lru_update(input lfr_pkg::lfr_req_t req);
        lfr_pkg::lfr_rsp_t rsp;
        int                pos;
        int                i;
        rsp = '0;
        case (req.kind)
            lfr_pkg::KIND_VICTIM:
            begin
                // Evict from the tail; an empty list gives nothing
                if (list_len > 0)
                begin
                    rsp.victim_valid = 1'b1;
                    rsp.victim_frame = lru_list[list_len-1];
                    in_list[lru_list[list_len-1]] = 1'b0;
                    list_len--;
                end
            end
            lfr_pkg::KIND_PIN:
            begin
                // Remove the frame if listed and close the gap
                if (req.frame_num < NUM_FRAMES && in_list[req.frame_num])
                begin
                    pos = 0;
                    while (pos < list_len && lru_list[pos] != req.frame_num)
                        pos++;
                    for (i = pos; i < list_len - 1; i++)
                        lru_list[i] = lru_list[i+1];
                    list_len--;
                    in_list[req.frame_num] = 1'b0;
                end
            end
            lfr_pkg::KIND_UNPIN:
            begin
                // Push a new frame at the head; a listed frame keeps its place
                if (req.frame_num < NUM_FRAMES && !in_list[req.frame_num]
                    && list_len < NUM_FRAMES)
                begin
                    for (i = list_len; i > 0; i--)
                        lru_list[i] = lru_list[i-1];
                    lru_list[0] = req.frame_num;
                    list_len++;
                    in_list[req.frame_num] = 1'b1;
                end
            end
            default:
            begin
                // Unused code: no change
            end
        endcase
        rsp.evictable_count = list_len[lfr_pkg::COUNT_W-1:0];
        return rsp;
    endfunction

    // Report one field mismatch
    task automatic report_field(input string name, input int exp_val, input int act_val);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
        errors++;
    endtask

    // Check results first, then predict the request taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        lfr_pkg::lfr_rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                lru_list[i] = '0;
                in_list[i]  = 1'b0;
            end
            list_len = 0;
            due_results.delete();
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result: valid=%0d frame=%0d count=%0d",
                             $time, result.victim_valid, result.victim_frame,
                             result.evictable_count);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.victim_valid !== want.victim_valid)
                        report_field("victim_valid", int'(want.victim_valid),
                                     int'(result.victim_valid));
                    if (result.victim_frame !== want.victim_frame)
                        report_field("victim_frame", int'(want.victim_frame),
                                     int'(result.victim_frame));
                    if (result.evictable_count !== want.evictable_count)
                        report_field("evictable_count", int'(want.evictable_count),
                                     int'(result.evictable_count));
                end
            end
            if (start && !busy)
                due_results.push_back(lru_update(item));
            outstanding = due_results.size();
        end
    end

endmodule

/* test/tb_lru_frame_replacer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_frame_replacer_top: testbench for the LRU frame replacer
// Drives a directed set of victim, pin and unpin requests covering the empty
// list, absent and repeated frames and the unused code, then random rounds
// that fill, drain and mix the list, sent in bursts with random gaps.
// Checking is done by the checker instance beside the block.
// ----------------------------------------------------------------------------
module tb_lru_frame_replacer_top;

    localparam int         NUM_FRAMES  = 64;
    localparam int         ITEM_TARGET = 1600;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    lfr_pkg::lfr_req_t item  = '0;
    logic              busy;
    logic              done;
    lfr_pkg::lfr_rsp_t result;
    int                errors;
    int                outstanding;

    int                burst_left = 0;
    int                sent       = 0;

    lru_frame_replacer_top #(
        .NUM_FRAMES (NUM_FRAMES)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    lru_frame_replacer_checker #(
        .NUM_FRAMES (NUM_FRAMES)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    // Send one request; open a new burst with a random gap when one runs out
    task automatic send_req(input logic [1:0] kind, input logic [lfr_pkg::ID_W-1:0] id);
        lfr_pkg::lfr_req_t req;
        int                gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.kind      = kind;
        req.frame_num = id;
        start <= 1'b1;
        item  <= req;
        // Hold until the transfer
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    // Pick a frame, from a narrow window when hits on listed frames are wanted
    function automatic logic [lfr_pkg::ID_W-1:0] pick_id(input bit narrow);
        int pick;
        pick = narrow ? $urandom_range(0, 7) : $urandom_range(0, NUM_FRAMES - 1);
        return pick[lfr_pkg::ID_W-1:0];
    endfunction

    initial
    begin
        int mode;
        int len;
        int stride;
        int base;
        int r;
        int fid;
        bit narrow;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, absent and repeated frames, unused code
        send_req(lfr_pkg::KIND_VICTIM, 6'd63);
        send_req(KIND_UNUSED,          6'd42);
        send_req(lfr_pkg::KIND_PIN,    6'd0);
        send_req(lfr_pkg::KIND_UNPIN,  6'd0);
        send_req(lfr_pkg::KIND_UNPIN,  6'd63);
        send_req(lfr_pkg::KIND_UNPIN,  6'd0);
        send_req(lfr_pkg::KIND_UNPIN,  6'd21);
        send_req(lfr_pkg::KIND_UNPIN,  6'd42);
        send_req(lfr_pkg::KIND_PIN,    6'd63);
        send_req(lfr_pkg::KIND_PIN,    6'd63);
        send_req(KIND_UNUSED,          6'd21);
        send_req(lfr_pkg::KIND_VICTIM, 6'd0);
        send_req(lfr_pkg::KIND_UNPIN,  6'd0);
        send_req(lfr_pkg::KIND_PIN,    6'd0);
        send_req(lfr_pkg::KIND_VICTIM, 6'd21);
        send_req(lfr_pkg::KIND_PIN,    6'd42);
        send_req(lfr_pkg::KIND_VICTIM, 6'd63);

        // Random rounds; the first one fills the list completely
        mode = 0;
        while (sent < ITEM_TARGET)
        begin
            narrow = ($urandom_range(0, 2) == 0);
            if (mode < 2)
            begin
                // Fill: unpin every frame in a scrambled order
                stride = 2 * $urandom_range(0, 31) + 1;
                base   = $urandom_range(0, NUM_FRAMES - 1);
                for (int k = 0; k < NUM_FRAMES; k++)
                begin
                    fid = (base + k * stride) % NUM_FRAMES;
                    send_req(lfr_pkg::KIND_UNPIN, fid[lfr_pkg::ID_W-1:0]);
                end
            end
            else if (mode < 5)
            begin
                // Drain: mostly evictions
                len = $urandom_range(8, 48);
                for (int k = 0; k < len; k++)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 7)
                        send_req(lfr_pkg::KIND_VICTIM, pick_id(1'b0));
                    else if (r < 9)
                        send_req(lfr_pkg::KIND_PIN, pick_id(narrow));
                    else
                        send_req(lfr_pkg::KIND_UNPIN, pick_id(narrow));
                end
            end
            else
            begin
                // Mix all operations
                len = $urandom_range(10, 60);
                for (int k = 0; k < len; k++)
                begin
                    r = $urandom_range(0, 19);
                    if (r < 8)
                        send_req(lfr_pkg::KIND_UNPIN, pick_id(narrow));
                    else if (r < 13)
                        send_req(lfr_pkg::KIND_PIN, pick_id(narrow));
                    else if (r < 19)
                        send_req(lfr_pkg::KIND_VICTIM, pick_id(1'b0));
                    else
                        send_req(KIND_UNUSED, pick_id(1'b0));
                end
            end
            mode = $urandom_range(0, 9);
        end
        start <= 1'b0;

        // Drain outstanding results, then allow the block to settle
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule
